### rtl/sblit_pkg.sv
package sblit_pkg;

  // Field widths of the request and result items.
  localparam int unsigned POS_X_W  = 11;
  localparam int unsigned POS_Y_W  = 8;
  localparam int unsigned WIDTH_W  = 10;
  localparam int unsigned HEIGHT_W = 8;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DEST_W   = 17;
  localparam int unsigned SRC_W    = 18;

  // One chunk is eight bytes, one byte per pixel.
  localparam int unsigned CHUNK_BYTES = 8;

  // Signed screen column wide enough for pos_x + sprite_width and any visible column.
  localparam int unsigned P_W   = 12;
  // Sprite column: reaches the sprite width plus one chunk.
  localparam int unsigned COL_W = 11;
  // Screen line of the row: pos_y + row_number.
  localparam int unsigned YSUM_W   = 9;
  localparam int unsigned YSUM_MAX = (2 ** POS_Y_W - 1) + (2 ** ROW_W - 1);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_COPY   = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_EMPTY  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0]        pos_y;
    logic [WIDTH_W-1:0]        sprite_width;
    logic [HEIGHT_W-1:0]       sprite_height;
    logic [ROW_W-1:0]          row_number;
    logic                      mirror_on;
    logic                      transparent_on;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic              target_select;
    logic [DEST_W-1:0] dest_offset;
    logic [SRC_W-1:0]  src_offset;
    logic              byte_reverse;
    logic              last_chunk;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic last;
  } dp_sts_t;

endpackage

### rtl/sblit_if.sv
interface sblit_req_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [sblit_pkg::POS_X_W-1:0]       pos_x;
  logic [sblit_pkg::POS_Y_W-1:0]              pos_y;
  logic [sblit_pkg::WIDTH_W-1:0]              sprite_width;
  logic [sblit_pkg::HEIGHT_W-1:0]             sprite_height;
  logic [sblit_pkg::ROW_W-1:0]                row_number;
  logic                                       mirror_on;
  logic                                       transparent_on;

  modport source (
    output valid, pos_x, pos_y, sprite_width, sprite_height, row_number, mirror_on,
           transparent_on,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, sprite_width, sprite_height, row_number, mirror_on,
           transparent_on,
    output ready
  );
endinterface

interface sblit_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [sblit_pkg::STATUS_W-1:0]    status;
  logic                              target_select;
  logic [sblit_pkg::DEST_W-1:0]      dest_offset;
  logic [sblit_pkg::SRC_W-1:0]       src_offset;
  logic                              byte_reverse;
  logic                              last_chunk;

  modport source (
    output valid, status, target_select, dest_offset, src_offset, byte_reverse, last_chunk,
    input  ready
  );

  modport sink (
    input  valid, status, target_select, dest_offset, src_offset, byte_reverse, last_chunk,
    output ready
  );
endinterface

### rtl/sprite_chunk_blit_address_gen.sv
// Sprite row blitter address generator.
// A request on req_i names one row of a sprite: position, size, row number,
// mirror and transparency flags. The block answers on cmd_o with the 8-byte
// chunk copy commands for that row, left to right in screen order, one per
// transfer; the final one carries last_chunk. A sprite with pos_x + width below
// zero or pos_x above SCREEN_PIXELS gives a single rejected result, and a row
// outside the sprite or with no visible chunk gives a single empty-row result.
// Timing: a request is taken only while no row is in progress. In the cycle after
// the transfer the row setup runs (line and source multiplies), then one command
// is loaded into the output register per cycle while that register can take it.
// The first command becomes valid from the output register after the setup step,
// and a row gives n commands, with n from 1 to SCREEN_PIXELS/8 + 1.
// When the receiver stalls, the output register holds its command and the
// sequencer waits. The next request may be taken while the final command of
// the previous row is still waiting in the output register.
// Reset clears the sequencer and the output valid; nothing else needs clearing.
module sprite_chunk_blit_address_gen #(
  parameter int unsigned SCREEN_PIXELS = 320,
  parameter int unsigned ROW_MARGIN    = 16,
  parameter int unsigned TABLE_BYTES   = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sblit_req_if.sink   req_i,
  sblit_cmd_if.source cmd_o
);

  sblit_pkg::req_t      req;
  sblit_pkg::res_t      res;
  sblit_pkg::ctrl_cmd_t cmd;
  sblit_pkg::dp_sts_t   sts;
  logic                 req_ready;
  logic                 out_valid;

  assign req.pos_x          = req_i.pos_x;
  assign req.pos_y          = req_i.pos_y;
  assign req.sprite_width   = req_i.sprite_width;
  assign req.sprite_height  = req_i.sprite_height;
  assign req.row_number     = req_i.row_number;
  assign req.mirror_on      = req_i.mirror_on;
  assign req.transparent_on = req_i.transparent_on;
  assign req_i.ready        = req_ready;

  sblit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sblit_dp #(
    .SCREEN_PIXELS (SCREEN_PIXELS),
    .ROW_MARGIN    (ROW_MARGIN),
    .TABLE_BYTES   (TABLE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (cmd_o.ready),
    .out_o       (res)
  );

  assign cmd_o.valid         = out_valid;
  assign cmd_o.status        = res.status;
  assign cmd_o.target_select = res.target_select;
  assign cmd_o.dest_offset   = res.dest_offset;
  assign cmd_o.src_offset    = res.src_offset;
  assign cmd_o.byte_reverse  = res.byte_reverse;
  assign cmd_o.last_chunk    = res.last_chunk;

`ifndef SYNTHESIS
  // A request starts a row; the block does not take another in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while a row setup is pending");

  // A rejected or empty row is a single result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid && (cmd_o.status != sblit_pkg::STATUS_COPY) |-> cmd_o.last_chunk)
    else $error("non-copy result without last mark");

  // Results other than copies carry no addresses.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid && (cmd_o.status != sblit_pkg::STATUS_COPY)
    |-> (cmd_o.dest_offset == '0) && (cmd_o.src_offset == '0)
        && !cmd_o.target_select && !cmd_o.byte_reverse)
    else $error("non-copy result carries address fields");
`endif

endmodule

### rtl/sblit_dp.sv
module sblit_dp #(
  parameter int unsigned SCREEN_PIXELS = 320,
  parameter int unsigned ROW_MARGIN    = 16,
  parameter int unsigned TABLE_BYTES   = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sblit_pkg::req_t       req_i,
  input  sblit_pkg::ctrl_cmd_t  cmd_i,
  output sblit_pkg::dp_sts_t    sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sblit_pkg::res_t       out_o
);

  localparam int unsigned Pitch     = SCREEN_PIXELS + ROW_MARGIN;
  localparam int unsigned ChunkCap  = SCREEN_PIXELS / sblit_pkg::CHUNK_BYTES + 1;
  localparam int unsigned CntW      = $clog2(ChunkCap + 1);
  localparam int unsigned LineMax   = TABLE_BYTES + sblit_pkg::YSUM_MAX * Pitch
                                      + sblit_pkg::CHUNK_BYTES;
  localparam int unsigned LineW     = $clog2(LineMax + 1);
  localparam int unsigned DestSumW  = ((LineW > sblit_pkg::DEST_W) ? LineW
                                       : sblit_pkg::DEST_W) + 1;
  localparam int unsigned SrcCalcW  = sblit_pkg::SRC_W + 2;
  localparam int unsigned RwProdW   = sblit_pkg::ROW_W + 1 + sblit_pkg::WIDTH_W;
  localparam int unsigned PW        = sblit_pkg::P_W;
  localparam int unsigned ColW      = sblit_pkg::COL_W;

  sblit_pkg::req_t          req_q;
  logic [LineW-1:0]         line_q, line_d;
  logic [sblit_pkg::SRC_W-1:0] rw_q, rw_d;
  logic [ColW-1:0]          col_q, col_init;
  logic signed [PW-1:0]     p_q, p_init;
  logic [CntW-1:0]          cnt_q;
  logic                     reject_q, reject_d;
  logic                     empty_q, empty_d;
  logic                     out_valid_q;
  sblit_pkg::res_t          out_q, res_d;

  // Setup terms, from the captured request.
  logic signed [PW-1:0]     x_ext, xw_sum, neg_x;
  logic                     left_clip;
  logic [sblit_pkg::YSUM_W-1:0] ysum;
  logic [sblit_pkg::ROW_W:0]    row_f;
  logic [RwProdW-1:0]       rw_prod;

  // Per-chunk terms.
  logic signed [DestSumW-1:0] dest_sum;
  logic signed [SrcCalcW-1:0] src_m;
  logic [sblit_pkg::SRC_W-1:0] src_val;
  logic signed [PW:0]       p_right;
  logic [ColW-1:0]          col_next;
  logic                     at_edge, last;

  always_comb begin
    x_ext     = PW'(req_q.pos_x);
    xw_sum    = x_ext + $signed(PW'(req_q.sprite_width));
    neg_x     = -x_ext;
    left_clip = x_ext < -$signed(PW'(sblit_pkg::CHUNK_BYTES));
    reject_d  = (xw_sum < 0) || (x_ext > $signed(PW'(SCREEN_PIXELS)));
    // When pos_x < -CHUNK_BYTES, skip whole chunks that lie left of the screen.
    col_init  = left_clip ? (neg_x[ColW-1:0] & ~ColW'(sblit_pkg::CHUNK_BYTES - 1)) : '0;
    p_init    = x_ext + $signed(PW'(col_init));
    empty_d   = (req_q.row_number >= req_q.sprite_height)
                || (col_init >= ColW'(req_q.sprite_width));
    ysum      = sblit_pkg::YSUM_W'(req_q.pos_y) + sblit_pkg::YSUM_W'(req_q.row_number);
    line_d    = LineW'(TABLE_BYTES + sblit_pkg::CHUNK_BYTES)
                + LineW'(ysum) * LineW'(Pitch);
    // A mirrored row is read back from the end of the row, (row + 1) * width.
    row_f     = (sblit_pkg::ROW_W + 1)'(req_q.row_number)
                + (sblit_pkg::ROW_W + 1)'(req_q.mirror_on);
    rw_prod   = RwProdW'(row_f) * RwProdW'(req_q.sprite_width);
    rw_d      = rw_prod[sblit_pkg::SRC_W-1:0];
  end

  always_comb begin
    dest_sum = $signed(DestSumW'(line_q)) + DestSumW'(p_q);
    src_m    = $signed(SrcCalcW'(rw_q)) - $signed(SrcCalcW'(col_q))
               - $signed(SrcCalcW'(sblit_pkg::CHUNK_BYTES));
    if (req_q.mirror_on) begin
      src_val = (src_m < 0) ? '0 : src_m[sblit_pkg::SRC_W-1:0];
    end else begin
      src_val = rw_q + sblit_pkg::SRC_W'(col_q);
    end
    p_right  = (PW + 1)'(p_q) + $signed((PW + 1)'(sblit_pkg::CHUNK_BYTES));
    at_edge  = p_right > $signed((PW + 1)'(SCREEN_PIXELS));
    col_next = col_q + ColW'(sblit_pkg::CHUNK_BYTES);
    last     = reject_q || empty_q || at_edge
               || (col_next >= ColW'(req_q.sprite_width))
               || (cnt_q == CntW'(ChunkCap - 1));

    res_d = '0;
    res_d.last_chunk = 1'b1;
    if (reject_q) begin
      res_d.status = sblit_pkg::STATUS_REJECT;
    end else if (empty_q) begin
      res_d.status = sblit_pkg::STATUS_EMPTY;
    end else begin
      res_d.status        = sblit_pkg::STATUS_COPY;
      res_d.target_select = req_q.transparent_on;
      res_d.dest_offset   = dest_sum[sblit_pkg::DEST_W-1:0];
      res_d.src_offset    = src_val;
      res_d.byte_reverse  = req_q.mirror_on;
      res_d.last_chunk    = last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.setup) begin
      line_q   <= line_d;
      rw_q     <= rw_d;
      col_q    <= col_init;
      p_q      <= p_init;
      cnt_q    <= '0;
      reject_q <= reject_d;
      empty_q  <= empty_d;
    end else if (cmd_i.emit) begin
      col_q <= col_next;
      p_q   <= p_q + $signed(PW'(sblit_pkg::CHUNK_BYTES));
      cnt_q <= cnt_q + CntW'(1);
    end
    if (cmd_i.emit) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.last     = last;
  assign out_valid_o    = out_valid_q;
  assign out_o          = out_q;

endmodule

### rtl/sblit_ctrl.sv
module sblit_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  sblit_pkg::dp_sts_t   sts_i,
  output sblit_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSetup = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSetup;
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = StRun;
      end
      StRun: begin
        // One result per cycle while the output register can take it.
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
